// ----- rtl/core/primitive_assembly_quad_to_triangle_assert.svh -----
// ----------------------------------------------------------------------------
// Primitive assembly assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRIMITIVE_ASSEMBLY_QUAD_TO_TRIANGLE_ASSERT_SVH
`define PRIMITIVE_ASSEMBLY_QUAD_TO_TRIANGLE_ASSERT_SVH

// Same-cycle implication.
`define PA_Q2T_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PA_Q2T_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pa_q2t_pkg.sv -----
// ----------------------------------------------------------------------------
// pa_q2t_pkg
// Shared types, codes and helpers of the quad-to-triangle primitive assembler.
// ----------------------------------------------------------------------------
package pa_q2t_pkg;

  localparam int HANDLE_WIDTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH          = 4;
  localparam int QUEUE_PTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int JOB_SLOTS            = 4;

  // Primitive modes (configuration register)
  localparam logic [2:0] MODE_LINES       = 3'd0;
  localparam logic [2:0] MODE_TRIANGLES   = 3'd1;
  localparam logic [2:0] MODE_QUADS       = 3'd2;
  localparam logic [2:0] MODE_LINE_STRIP  = 3'd3;
  localparam logic [2:0] MODE_LINE_LOOP   = 3'd4;
  localparam logic [2:0] MODE_TRI_STRIP   = 3'd5;
  localparam logic [2:0] MODE_QUAD_STRIP  = 3'd6;
  localparam logic [2:0] MODE_FAN         = 3'd7;
  localparam logic [2:0] MODE_RESET       = MODE_TRIANGLES;

  // Draw codes for the back end
  localparam logic [2:0] DRAW_LINES       = 3'd0;
  localparam logic [2:0] DRAW_TRIANGLES   = 3'd1;
  localparam logic [2:0] DRAW_LINE_STRIP  = 3'd2;
  localparam logic [2:0] DRAW_TRI_STRIP   = 3'd3;
  localparam logic [2:0] DRAW_FAN         = 3'd4;

  // Input commands
  localparam logic CMD_VERTEX = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // Register index (paddr[2])
  localparam logic REG_MODE = 1'b0;

  // Six-item triangle pair
  localparam logic [2:0] SIX_LAST = 3'd5;
  localparam logic [1:0] QUAD_LAST_POS = 2'd3;
  localparam logic [1:0] STRIP_PRIME_POS = 2'd2;

  typedef struct packed {
    logic       six;     // expand to a triangle pair
    logic       valid;   // vertex_valid for a single item
    logic [2:0] prim;    // draw code for a single item
    logic       bend;    // batch end for a single item
  } job_ctrl_t;

  function automatic logic [2:0] draw_code(input logic [2:0] mode);
    logic [2:0] code;
    unique case (mode)
      MODE_LINES:      code = DRAW_LINES;
      MODE_TRIANGLES:  code = DRAW_TRIANGLES;
      MODE_QUADS:      code = DRAW_TRIANGLES;
      MODE_LINE_STRIP: code = DRAW_LINE_STRIP;
      MODE_LINE_LOOP:  code = DRAW_LINE_STRIP;
      MODE_TRI_STRIP:  code = DRAW_TRI_STRIP;
      MODE_QUAD_STRIP: code = DRAW_TRIANGLES;
      MODE_FAN:        code = DRAW_FAN;
      default:         code = DRAW_TRIANGLES;
    endcase
    return code;
  endfunction

  // Slot order of a triangle pair: w0,w1,w2,w0,w2,w3
  function automatic logic [1:0] six_slot(input logic [2:0] step);
    logic [1:0] slot;
    unique case (step)
      3'd0:    slot = 2'd0;
      3'd1:    slot = 2'd1;
      3'd2:    slot = 2'd2;
      3'd3:    slot = 2'd0;
      3'd4:    slot = 2'd2;
      3'd5:    slot = 2'd3;
      default: slot = 2'd0;
    endcase
    return slot;
  endfunction

endpackage

// ----- rtl/core/pa_q2t_front.sv -----
// ----------------------------------------------------------------------------
// pa_q2t_front
// Takes input items, tracks batch state and classifies each into a job.
// ----------------------------------------------------------------------------
module pa_q2t_front #(
  parameter int HANDLE_WIDTH = pa_q2t_pkg::HANDLE_WIDTH_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [2:0]                               mode,
  input  logic                                     accept,
  input  logic                                     command,
  input  logic [HANDLE_WIDTH-1:0]                  vertex_handle,
  output logic                                     job_push,
  output pa_q2t_pkg::job_ctrl_t                    job_ctrl,
  output logic [pa_q2t_pkg::JOB_SLOTS*HANDLE_WIDTH-1:0] job_handles
);
  import pa_q2t_pkg::*;

  logic [HANDLE_WIDTH-1:0] recent [3];
  logic [HANDLE_WIDTH-1:0] first_vertex;
  logic [1:0]              pos;
  logic                    primed;
  logic                    nonempty;

  logic [HANDLE_WIDTH-1:0] zero_handle;
  logic                    has_job;

  assign zero_handle = '0;

  always_comb begin
    has_job     = 1'b0;
    job_ctrl    = '{six: 1'b0, valid: 1'b1, prim: draw_code(mode), bend: 1'b0};
    job_handles = {zero_handle, zero_handle, zero_handle, vertex_handle};
    if (command == CMD_FLUSH) begin
      has_job        = nonempty;
      job_ctrl.bend  = 1'b1;
      job_ctrl.valid = (mode == MODE_LINE_LOOP);
      job_handles    = {zero_handle, zero_handle, zero_handle,
                        job_ctrl.valid ? first_vertex : zero_handle};
    end else if (mode == MODE_QUADS) begin
      has_job      = (pos == QUAD_LAST_POS);
      job_ctrl.six = 1'b1;
      job_handles  = {vertex_handle, recent[2], recent[1], recent[0]};
    end else if (mode == MODE_QUAD_STRIP) begin
      has_job      = pos[0] && primed;
      job_ctrl.six = 1'b1;
      job_handles  = {recent[2], vertex_handle, recent[1], recent[0]};
    end else begin
      has_job = 1'b1;
    end
  end

  assign job_push = accept && has_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      primed   <= 1'b0;
      nonempty <= 1'b0;
    end else if (accept) begin
      if (command == CMD_FLUSH) begin
        pos      <= '0;
        primed   <= 1'b0;
        nonempty <= 1'b0;
      end else begin
        pos      <= pos + 2'd1;
        nonempty <= 1'b1;
        if (pos == STRIP_PRIME_POS) begin
          primed <= 1'b1;
        end
      end
    end
  end

  // Handle history: no reset, counters guard every read
  always_ff @(posedge clk) begin
    if (accept && command == CMD_VERTEX) begin
      recent[0] <= recent[1];
      recent[1] <= recent[2];
      recent[2] <= vertex_handle;
      if (!nonempty) begin
        first_vertex <= vertex_handle;
      end
    end
  end

endmodule

// ----- rtl/core/pa_q2t_queue.sv -----
// ----------------------------------------------------------------------------
// pa_q2t_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module pa_q2t_queue #(
  parameter int HANDLE_WIDTH = pa_q2t_pkg::HANDLE_WIDTH_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          wr_en,
  input  pa_q2t_pkg::job_ctrl_t                         wr_ctrl,
  input  logic [pa_q2t_pkg::JOB_SLOTS*HANDLE_WIDTH-1:0] wr_handles,
  input  logic                                          rd_en,
  output pa_q2t_pkg::job_ctrl_t                         rd_ctrl,
  output logic [pa_q2t_pkg::JOB_SLOTS*HANDLE_WIDTH-1:0] rd_handles,
  output logic                                          q_full,
  output logic                                          q_empty,
  output logic [pa_q2t_pkg::QUEUE_CNT_W-1:0]            q_count
);
  import pa_q2t_pkg::*;

  job_ctrl_t                         ctrl_mem   [QUEUE_DEPTH];
  logic [JOB_SLOTS*HANDLE_WIDTH-1:0] handle_mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]            wr_ptr;
  logic [QUEUE_PTR_W-1:0]            rd_ptr;
  logic                              do_wr;
  logic                              do_rd;

  assign q_full  = (q_count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_empty = (q_count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  assign rd_ctrl    = ctrl_mem[rd_ptr];
  assign rd_handles = handle_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        q_count <= q_count + 1'b1;
      end else if (do_rd && !do_wr) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ctrl_mem[wr_ptr]   <= wr_ctrl;
      handle_mem[wr_ptr] <= wr_handles;
    end
  end

endmodule

// ----- rtl/core/pa_q2t_back.sv -----
// ----------------------------------------------------------------------------
// pa_q2t_back
// Expands queued jobs into result items in an output register, one per cycle unless held.
// ----------------------------------------------------------------------------
module pa_q2t_back #(
  parameter int HANDLE_WIDTH = pa_q2t_pkg::HANDLE_WIDTH_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          job_avail,
  input  pa_q2t_pkg::job_ctrl_t                         job_ctrl,
  input  logic [pa_q2t_pkg::JOB_SLOTS*HANDLE_WIDTH-1:0] job_handles,
  output logic                                          job_pop,
  input  logic                                          pop,
  output logic                                          empty,
  output logic [HANDLE_WIDTH-1:0]                       out_vertex,
  output logic                                          vertex_valid,
  output logic [2:0]                                    draw_primitive,
  output logic                                          batch_end,
  output logic                                          run_last
);
  import pa_q2t_pkg::*;

  logic       out_valid;
  logic [2:0] step;
  logic       load;
  logic       last_of_job;
  logic [1:0] slot;

  assign load        = job_avail && (!out_valid || pop);
  assign last_of_job = !job_ctrl.six || (step == SIX_LAST);
  assign job_pop     = load && last_of_job;
  assign slot        = job_ctrl.six ? six_slot(step) : 2'd0;
  assign empty       = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= last_of_job ? 3'd0 : step + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_vertex     <= job_handles[slot*HANDLE_WIDTH +: HANDLE_WIDTH];
      vertex_valid   <= job_ctrl.six ? 1'b1 : job_ctrl.valid;
      draw_primitive <= job_ctrl.six ? DRAW_TRIANGLES : job_ctrl.prim;
      batch_end      <= job_ctrl.six ? 1'b0 : job_ctrl.bend;
      run_last       <= last_of_job;
    end
  end

endmodule

// ----- rtl/core/primitive_assembly_quad_to_triangle.sv -----
// Path: an accepted item is written into the job queue, then loaded into the output register.
// Throughput: one input item per cycle while the four-deep job queue has room; results leave
//   at one per cycle while the receiver pops, and a complete quad gives six results for 4 items.
// The single result port sets the sustained rate for quads and quad strips.
// Reset (rst, synchronous, active high): queue and output register empty, batch counters
//   cleared, primitive_mode returns to triangles; stored handles are not cleared.
// ----------------------------------------------------------------------------
// primitive_assembly_quad_to_triangle
// Rewrites quads and quad strips into triangle pairs and closes line loops as line strips.
// ----------------------------------------------------------------------------
`include "primitive_assembly_quad_to_triangle_assert.svh"

module primitive_assembly_quad_to_triangle #(
  parameter int HANDLE_WIDTH = pa_q2t_pkg::HANDLE_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // input items
  input  logic                    push,
  output logic                    full,
  input  logic                    command,
  input  logic [HANDLE_WIDTH-1:0] vertex_handle,
  // result items
  output logic                    empty,
  input  logic                    pop,
  output logic [HANDLE_WIDTH-1:0] out_vertex,
  output logic                    vertex_valid,
  output logic [2:0]              draw_primitive,
  output logic                    batch_end,
  output logic                    run_last
);
  import pa_q2t_pkg::*;

  logic [2:0]                        mode;
  logic                              cfg_write;
  logic                              accept;
  logic                              job_push;
  job_ctrl_t                         job_ctrl_in;
  logic [JOB_SLOTS*HANDLE_WIDTH-1:0] job_handles_in;
  job_ctrl_t                         job_ctrl_out;
  logic [JOB_SLOTS*HANDLE_WIDTH-1:0] job_handles_out;
  logic                              job_pop;
  logic                              q_empty;
  logic [QUEUE_CNT_W-1:0]            q_count;

  // Configuration: one register, primitive_mode, at byte address 0.
  // pready is tied high, so every access completes in its access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_MODE) ? {29'd0, mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (cfg_write && paddr[2] == REG_MODE) begin
      mode <= pwdata[2:0];
    end
  end

  // Front: accept an item whenever the job queue has room; items that
  // produce no result (incomplete quad, empty batch end) update state only.
  assign accept = push && !full;

  pa_q2t_front #(
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .mode          (mode),
    .accept        (accept),
    .command       (command),
    .vertex_handle (vertex_handle),
    .job_push      (job_push),
    .job_ctrl      (job_ctrl_in),
    .job_handles   (job_handles_in)
  );

  // Queue: decouple the front from the back so each side stalls on its own.
  pa_q2t_queue #(
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (job_push),
    .wr_ctrl    (job_ctrl_in),
    .wr_handles (job_handles_in),
    .rd_en      (job_pop),
    .rd_ctrl    (job_ctrl_out),
    .rd_handles (job_handles_out),
    .q_full     (full),
    .q_empty    (q_empty),
    .q_count    (q_count)
  );

  // Back: drain one job, one result item per cycle while the output register is free or popped.
  pa_q2t_back #(
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_avail      (!q_empty),
    .job_ctrl       (job_ctrl_out),
    .job_handles    (job_handles_out),
    .job_pop        (job_pop),
    .pop            (pop),
    .empty          (empty),
    .out_vertex     (out_vertex),
    .vertex_valid   (vertex_valid),
    .draw_primitive (draw_primitive),
    .batch_end      (batch_end),
    .run_last       (run_last)
  );

  // Checks
  `PA_Q2T_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= QUEUE_CNT_W'(QUEUE_DEPTH), "job queue overrun")
  `PA_Q2T_ASSERT_NOW(a_marker_bare, !empty && !vertex_valid, batch_end && out_vertex == '0, "bad marker item")
  `PA_Q2T_ASSERT_NOW(a_end_is_last, !empty && batch_end, run_last, "batch end not last of its run")
  `PA_Q2T_ASSERT_NEXT(a_push_fills, accept && job_push && !job_pop, !q_empty, "job lost on push")

endmodule

// ----- verif/pa_q2t_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad-to-triangle assembly checker
// Watches the vertex, result and register channels, predicts the draw stream
// and compares every result item with the oldest one due.
// ----------------------------------------------------------------------------
module pa_q2t_checker #(
  parameter int HW = pa_q2t_pkg::HANDLE_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  input  logic [31:0]   prdata,
  input  logic          pready,
  input  logic          push,
  input  logic          full,
  input  logic          command,
  input  logic [HW-1:0] vertex_handle,
  input  logic          empty,
  input  logic          pop,
  input  logic [HW-1:0] out_vertex,
  input  logic          vertex_valid,
  input  logic [2:0]    draw_primitive,
  input  logic          batch_end,
  input  logic          run_last,
  output int            failures,
  output int            due_count,
  output int            results_checked
);
  import pa_q2t_pkg::*;

  localparam logic [2:0] MODE_ADDR = {REG_MODE, 2'b00};

  typedef struct packed {
    logic [HW-1:0] vertex;
    logic          valid;
    logic [2:0]    prim;
    logic          bend;
    logic          ends_run;
  } emit_t;

  emit_t         due[$];
  logic [2:0]    mode;
  logic [HW-1:0] recent [3];
  logic [HW-1:0] first_vtx;
  logic [1:0]    quad_pos;
  logic          primed;
  logic          in_batch;
  int            fails = 0;
  int            checked = 0;
  int            waiting = 0;

  assign failures        = fails;
  assign due_count       = waiting;
  assign results_checked = checked;

  task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    fails++;
  endtask

  function automatic logic [2:0] draw_for(input logic [2:0] m);
    case (m)
      MODE_LINES:                                  return DRAW_LINES;
      MODE_TRIANGLES, MODE_QUADS, MODE_QUAD_STRIP: return DRAW_TRIANGLES;
      MODE_LINE_STRIP, MODE_LINE_LOOP:             return DRAW_LINE_STRIP;
      MODE_TRI_STRIP:                              return DRAW_TRI_STRIP;
      default:                                     return DRAW_FAN;
    endcase
  endfunction

  task automatic queue_one(input logic [HW-1:0] v, input logic valid, input logic [2:0] prim,
                           input logic bend);
    emit_t e;
    e.vertex   = v;
    e.valid    = valid;
    e.prim     = prim;
    e.bend     = bend;
    e.ends_run = 1'b0;
    due.insert(due.size(), e);
  endtask

  // Two triangles w0,w1,w2 and w0,w2,w3
  task automatic queue_pair(input logic [HW-1:0] w0, input logic [HW-1:0] w1,
                            input logic [HW-1:0] w2, input logic [HW-1:0] w3);
    queue_one(w0, 1'b1, DRAW_TRIANGLES, 1'b0);
    queue_one(w1, 1'b1, DRAW_TRIANGLES, 1'b0);
    queue_one(w2, 1'b1, DRAW_TRIANGLES, 1'b0);
    queue_one(w0, 1'b1, DRAW_TRIANGLES, 1'b0);
    queue_one(w2, 1'b1, DRAW_TRIANGLES, 1'b0);
    queue_one(w3, 1'b1, DRAW_TRIANGLES, 1'b0);
  endtask

  task automatic assemble(input logic cmd, input logic [HW-1:0] h);
    logic [2:0]    code;
    logic [1:0]    pos;
    logic [HW-1:0] a, b, c;
    int            before_n;
    code     = draw_for(mode);
    pos      = quad_pos;
    a        = recent[0];
    b        = recent[1];
    c        = recent[2];
    before_n = due.size();
    if (cmd == CMD_FLUSH) begin
      if (in_batch) begin
        if (mode == MODE_LINE_LOOP) queue_one(first_vtx, 1'b1, code, 1'b1);
        else queue_one('0, 1'b0, code, 1'b1);
      end
      quad_pos = '0;
      primed   = 1'b0;
      in_batch = 1'b0;
    end else begin
      if (!in_batch) first_vtx = h;
      if (mode == MODE_QUADS) begin
        if (pos == QUAD_LAST_POS) queue_pair(a, b, c, h);
      end else if (mode == MODE_QUAD_STRIP) begin
        if (pos[0] && primed) queue_pair(a, b, h, c);
      end else begin
        queue_one(h, 1'b1, code, 1'b0);
      end
      recent[0] = b;
      recent[1] = c;
      recent[2] = h;
      if (pos == STRIP_PRIME_POS) primed = 1'b1;
      quad_pos = pos + 2'd1;
      in_batch = 1'b1;
    end
    if (due.size() > before_n) due[due.size() - 1].ends_run = 1'b1;
  endtask

  always @(posedge clk) begin
    emit_t want;
    if (rst) begin
      due.delete();
      mode      = MODE_RESET;
      quad_pos  = '0;
      primed    = 1'b0;
      in_batch  = 1'b0;
      first_vtx = '0;
      recent[0] = '0;
      recent[1] = '0;
      recent[2] = '0;
    end else begin
      // results pass through the job queue and the output register before they leave, so compare first
      if (pop && !empty) begin
        checked++;
        if (due.size() == 0) begin
          flag("result with nothing due", 64'(out_vertex), 64'd0);
        end else begin
          want = due.pop_front();
          if (out_vertex !== want.vertex)
            flag("out_vertex", 64'(out_vertex), 64'(want.vertex));
          if (vertex_valid !== want.valid)
            flag("vertex_valid", 64'(vertex_valid), 64'(want.valid));
          if (draw_primitive !== want.prim)
            flag("draw_primitive", 64'(draw_primitive), 64'(want.prim));
          if (batch_end !== want.bend)
            flag("batch_end", 64'(batch_end), 64'(want.bend));
          if (run_last !== want.ends_run)
            flag("run_last", 64'(run_last), 64'(want.ends_run));
        end
      end
      // an item taken at this edge still sees the mode held before it
      if (push && !full) assemble(command, vertex_handle);
      if (psel && penable && pready && paddr == MODE_ADDR) begin
        if (pwrite) mode = pwdata[2:0];
        else if (prdata !== {29'b0, mode})
          flag("primitive_mode read-back", 64'(prdata), 64'(mode));
      end
    end
    waiting = due.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad-to-triangle assembler testbench
// Drives vertex and end-of-batch items under every primitive mode, with bursty
// input, a wandering result stall and one long hold-off; the checker beside
// the block predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import pa_q2t_pkg::*;

  localparam int         HW            = HANDLE_WIDTH_DEFAULT;
  localparam logic [2:0] MODE_ADDR     = {REG_MODE, 2'b00};
  localparam int         STALL_LIMIT   = 2000;  // quiet cycles before the run is called hung
  localparam int         HOLD_CYCLES   = 200;   // long receiver hold-off
  localparam int         SETTLE_CYCLES = 10;    // drain time for items that give no result
  localparam int         RANDOM_ITEMS  = 260;

  logic          clk = 1'b0;
  logic          rst;
  logic          psel, penable, pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata, prdata;
  logic          pready;
  logic          push, full, command;
  logic [HW-1:0] vertex_handle;
  logic          empty, pop;
  logic [HW-1:0] out_vertex;
  logic          vertex_valid;
  logic [2:0]    draw_primitive;
  logic          batch_end, run_last;

  int failures, due_count, results_checked;

  // Stimulus bookkeeping
  int         items_sent    = 0;
  int         flushes_sent  = 0;
  int         burst_left    = 0;
  int         mode_writes   = 0;
  int         hold_requests = 0;
  logic [7:0] modes_seen    = '0;

  always #4 clk = ~clk;

  primitive_assembly_quad_to_triangle #(.HANDLE_WIDTH(HW)) DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .command(command), .vertex_handle(vertex_handle),
    .empty(empty), .pop(pop), .out_vertex(out_vertex), .vertex_valid(vertex_valid),
    .draw_primitive(draw_primitive), .batch_end(batch_end), .run_last(run_last)
  );

  pa_q2t_checker #(.HW(HW)) u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .command(command), .vertex_handle(vertex_handle),
    .empty(empty), .pop(pop), .out_vertex(out_vertex), .vertex_valid(vertex_valid),
    .draw_primitive(draw_primitive), .batch_end(batch_end), .run_last(run_last),
    .failures(failures), .due_count(due_count), .results_checked(results_checked)
  );

  // Mostly random handles, with the all-zero and all-one extremes now and then
  function automatic logic [HW-1:0] random_handle();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return HW'($urandom);
  endfunction

  // Present one item from the falling edge and hold it until the block takes it
  task automatic offer(input logic cmd, input logic [HW-1:0] h);
    @(negedge clk);
    push          <= 1'b1;
    command       <= cmd;
    vertex_handle <= h;
    do @(posedge clk); while (full);
  endtask

  // Send in bursts: when a burst runs out, drop push for a random gap first
  task automatic send(input logic cmd, input logic [HW-1:0] h);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    offer(cmd, h);
    items_sent++;
    if (cmd == CMD_FLUSH) flushes_sent++;
  endtask

  // Stop offering, wait for every due result, then let dropped vertices drain
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (due_count != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register access: setup cycle, then access cycle until pready
  task automatic apb_cycle(input logic wr, input logic [2:0] m);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MODE_ADDR;
    pwdata  <= {29'b0, m};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the mode and read it back; only call while the block is idle
  task automatic set_mode(input logic [2:0] m);
    apb_cycle(1'b1, m);
    apb_cycle(1'b0, '0);
    modes_seen[m] = 1'b1;
    mode_writes++;
  endtask

  // Mostly whole batches with random content; now and then a lone end-of-batch
  // (often on an empty batch) or a batch left open for the next mode
  task automatic random_phase(input int quota);
    int start, kind, len, k;
    start = items_sent;
    while (items_sent - start < quota) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send(CMD_FLUSH, random_handle());
      end else begin
        len = 4 * $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0) len += $urandom_range(1, 3);
        for (k = 0; k < len; k++) send(CMD_VERTEX, random_handle());
        if (kind != 1) send(CMD_FLUSH, random_handle());
      end
    end
  endtask

  // Receiver: a stall rate that wanders between none and heavy, plus the long
  // hold-off whenever the stimulus asks for one
  initial begin : result_drain
    int holds_done, pct, left;
    holds_done = 0;
    pct        = 0;
    left       = 0;
    pop        = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        if (left == 0) begin
          left = $urandom_range(20, 80);
          case ($urandom_range(0, 3))
            0:       pct = 0;
            1:       pct = 30;
            2:       pct = 60;
            default: pct = 90;
          endcase
        end
        left--;
        pop <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int i, phase, directed_end;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    push          = 1'b0;
    command       = CMD_VERTEX;
    vertex_handle = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset mode is triangles: read it back before touching it
    apb_cycle(1'b0, '0);
    modes_seen[MODE_TRIANGLES] = 1'b1;

    // End of an empty batch gives nothing; then both handle extremes
    send(CMD_FLUSH, '1);
    send(CMD_VERTEX, '0);
    send(CMD_VERTEX, '1);
    send(CMD_FLUSH, '0);

    // Quads: one whole quad, then two leftovers dropped at end of batch
    settle();
    set_mode(MODE_QUADS);
    for (i = 0; i < 6; i++) send(CMD_VERTEX, HW'(32'hA000_0001 + i));
    send(CMD_FLUSH, '0);

    // Quad strip: index one gives nothing, pairs at indexes three and five
    settle();
    set_mode(MODE_QUAD_STRIP);
    for (i = 0; i < 6; i++) send(CMD_VERTEX, HW'(32'hB000_0001 + i));
    send(CMD_FLUSH, '0);

    // Line loop: the end of batch repeats the first vertex
    settle();
    set_mode(MODE_LINE_LOOP);
    for (i = 0; i < 3; i++) send(CMD_VERTEX, HW'(32'hC000_0001 + i));
    send(CMD_FLUSH, '0);

    // Mode change mid-batch: two lines, then quads completes on the count so far
    settle();
    set_mode(MODE_LINES);
    send(CMD_VERTEX, HW'(32'hD000_0001));
    send(CMD_VERTEX, HW'(32'hD000_0002));
    settle();
    set_mode(MODE_QUADS);
    send(CMD_VERTEX, HW'(32'hD000_0003));
    send(CMD_VERTEX, HW'(32'hD000_0004));
    send(CMD_FLUSH, '0);

    // Pressure: hold the receiver off while a long quad strip keeps coming,
    // so the job queue fills and push stalls on full
    settle();
    set_mode(MODE_QUAD_STRIP);
    @(posedge clk);
    hold_requests++;
    burst_left = 24;
    for (i = 0; i < 22; i++) send(CMD_VERTEX, random_handle());
    send(CMD_FLUSH, random_handle());
    directed_end = items_sent;

    // Random phases: every mode once in order, then random modes; each write
    // happens only once the block has drained
    phase = 0;
    while (items_sent < directed_end + RANDOM_ITEMS) begin
      settle();
      if (phase < 8) set_mode(3'(phase));
      else set_mode(3'($urandom_range(0, 7)));
      random_phase($urandom_range(20, 40));
      phase++;
    end

    // Drain everything, then allow for any straggler
    settle();
    repeat (20) @(negedge clk);

    $display("Run covered %0d items (%0d end-of-batch) and %0d result items checked",
             items_sent, flushes_sent, results_checked);
    $display("Mode writes %0d, modes exercised 0x%02h, long receiver hold-offs %0d",
             mode_writes, modes_seen, hold_requests);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
